>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for clocked checks on clk_i with reset rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check, also checked while in reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/lls_pkg.sv
// ----------------------------------------------------------------------------
// lls_pkg
// shared types and constants of the lru limited set
// ----------------------------------------------------------------------------
package lls_pkg;

  localparam int unsigned KeyFieldW = 32;
  localparam int unsigned OccW      = 5;
  localparam int unsigned CapW      = 5;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [KeyFieldW-1:0] key;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic                 evicted;
    logic [KeyFieldW-1:0] evicted_key;
    logic [OccW-1:0]      occupancy;
  } out_t;

endpackage

>>> rtl/lls_match.sv
// ----------------------------------------------------------------------------
// lls_match
// associative compare of one key against every held slot
// ----------------------------------------------------------------------------
module lls_match #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic [KEY_WIDTH-1:0] keys_i [ENTRIES],
  input  logic [ENTRIES-1:0]   valid_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  output logic [ENTRIES-1:0]   match_o
);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_o[i] = valid_i[i] && (keys_i[i] == key_i);
    end
  end

endmodule

>>> rtl/lls_store.sv
// ----------------------------------------------------------------------------
// lls_store
// recency ordered key slots, valid bits and held count with their update
// ----------------------------------------------------------------------------
module lls_store
  import lls_pkg::*;
#(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned CNT_W     = $clog2(ENTRIES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  cmd_e                 cmd_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [ENTRIES-1:0]   match_i,
  input  logic [CapW-1:0]      cap_i,
  output logic [KEY_WIDTH-1:0] keys_o [ENTRIES],
  output logic [ENTRIES-1:0]   valid_o,
  output logic                 found_o,
  output logic                 evicted_o,
  output logic [KEY_WIDTH-1:0] evicted_key_o,
  output logic [CNT_W-1:0]     held_o
);

  localparam logic [7:0] EntriesW = 8'(ENTRIES);

  logic [KEY_WIDTH-1:0] keys_q [ENTRIES];
  logic [KEY_WIDTH-1:0] keys_d [ENTRIES];
  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic [CNT_W-1:0]     held_q, held_d;

  logic [ENTRIES-1:0]   pre;
  logic [ENTRIES-1:0]   last;
  logic [ENTRIES:0]     valid_ext;
  logic [KEY_WIDTH-1:0] tail_key;
  logic [7:0]           eff_cap;
  logic                 full;
  logic                 hit, run;
  logic                 do_front, do_ins, do_del;

  assign hit       = |match_i;
  assign valid_ext = {1'b0, valid_q};
  assign do_front  = hit && ((cmd_i == CMD_QUERY) || (cmd_i == CMD_ADD));
  assign do_ins    = !hit && (cmd_i == CMD_ADD);
  assign do_del    = hit && (cmd_i == CMD_REMOVE);

  // capacity zero acts as one, above the slot count it saturates
  always_comb begin
    eff_cap = 8'(cap_i);
    if (eff_cap == 8'd0) begin
      eff_cap = 8'd1;
    end
    if (eff_cap > EntriesW) begin
      eff_cap = EntriesW;
    end
  end

  assign full = (8'(held_q) >= eff_cap) && (held_q != '0);

  always_comb begin
    run      = 1'b0;
    tail_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      run     = run | match_i[i];
      pre[i]  = run;
      last[i] = valid_q[i] & ~valid_ext[i+1];
      if (last[i]) begin
        tail_key = tail_key | keys_q[i];
      end
    end
  end

  always_comb begin
    keys_d  = keys_q;
    valid_d = valid_q;
    held_d  = held_q;
    if (do_front) begin
      keys_d[0] = key_i;
      for (int i = 1; i < ENTRIES; i++) begin
        if (!pre[i-1]) begin
          keys_d[i] = keys_q[i-1];
        end
      end
    end else if (do_ins) begin
      keys_d[0]  = key_i;
      valid_d[0] = 1'b1;
      for (int i = 1; i < ENTRIES; i++) begin
        if (full ? valid_q[i] : valid_q[i-1]) begin
          keys_d[i]  = keys_q[i-1];
          valid_d[i] = valid_q[i-1];
        end
      end
      if (!full) begin
        held_d = held_q + CNT_W'(1);
      end
    end else if (do_del) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (pre[i]) begin
          keys_d[i]  = keys_q[i+1];
          valid_d[i] = valid_q[i+1];
        end
      end
      if (pre[ENTRIES-1]) begin
        valid_d[ENTRIES-1] = 1'b0;
      end
      held_d = held_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      keys_q <= keys_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      held_q  <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
      held_q  <= held_d;
    end
  end

  assign keys_o        = keys_q;
  assign valid_o       = valid_q;
  assign found_o       = hit;
  assign evicted_o     = do_ins && full;
  assign evicted_key_o = (do_ins && full) ? tail_key : '0;
  assign held_o        = held_d;

endmodule

>>> rtl/lru_limited_set.sv
// ----------------------------------------------------------------------------
// lru_limited_set
// fully associative key set in recency order with least recently used
// eviction at a programmable capacity
// ----------------------------------------------------------------------------
//  channel   direction  ports                                  payload
//  in        input      in_valid_i / in_ready_o / in_data_i    in_t
//  out       output     out_valid_o / out_ready_i / out_data_o out_t
//  cfg       input      cfg_we_i / cfg_wdata_i                 capacity
//
//  one transaction per cycle sustained while out_ready_i holds; the result goes
//  through the input register, then the compare and slot shift over all
//  entries into the result register
//  reset clears the slot valid bits, the held count and both valid flags; capacity resets to 16
//  a stalled result holds the result register and the input register fills,
//  after which in_ready_o drops until out_ready_i returns
// ----------------------------------------------------------------------------
module lru_limited_set
  import lls_pkg::*;
#(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_t            out_data_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  in_t                  in_q;
  logic                 in_vld_q;
  out_t                 out_q, out_d;
  logic                 out_vld_q;
  logic [CapW-1:0]      cap_q;
  logic                 adv;

  logic [63:0]          key_ext;
  logic [KEY_WIDTH-1:0] key_w;
  logic [KEY_WIDTH-1:0] keys [ENTRIES];
  logic [ENTRIES-1:0]   valid;
  logic [ENTRIES-1:0]   match;
  logic                 found, evicted;
  logic [KEY_WIDTH-1:0] ev_key;
  logic [63:0]          ev_ext;
  logic [CntW-1:0]      held;
  logic [7:0]           held_ext;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  assign key_ext = 64'(in_q.key);
  assign key_w   = key_ext[KEY_WIDTH-1:0];

  lls_match #(
    .ENTRIES  (ENTRIES),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_match (
    .keys_i (keys),
    .valid_i(valid),
    .key_i  (key_w),
    .match_o(match)
  );

  lls_store #(
    .ENTRIES  (ENTRIES),
    .KEY_WIDTH(KEY_WIDTH),
    .CNT_W    (CntW)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .cmd_i        (in_q.cmd),
    .key_i        (key_w),
    .match_i      (match),
    .cap_i        (cap_q),
    .keys_o       (keys),
    .valid_o      (valid),
    .found_o      (found),
    .evicted_o    (evicted),
    .evicted_key_o(ev_key),
    .held_o       (held)
  );

  assign ev_ext   = 64'(ev_key);
  assign held_ext = 8'(held);

  always_comb begin
    out_d.found       = found;
    out_d.evicted     = evicted;
    out_d.evicted_key = ev_ext[KeyFieldW-1:0];
    out_d.occupancy   = held_ext[OccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cap_q     <= CapReset;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/lls_checker.sv
// ----------------------------------------------------------------------------
// lls_checker
// port level checks of the lru limited set, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lls_checker
  import lls_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input out_t            out_data_o
);

  logic out_stall;
  logic out_evict;
  logic out_keep;
  logic evict_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_evict = out_valid_o && out_data_o.evicted;
  assign out_keep  = out_valid_o && !out_data_o.evicted;
  assign evict_ok  = !out_data_o.found && (out_data_o.occupancy != '0);

  // an eviction only happens on an add of an absent key
  `ASSERT_CLK(a_evict_miss, out_evict |-> evict_ok, "eviction on a hit or an empty set")

  // evicted key reads zero when nothing was pushed out
  `ASSERT_CLK(a_evict_key_zero, out_keep |-> out_data_o.evicted_key == '0, "stray evicted key")

  // input side only stalls behind a stalled result
  `ASSERT_ALWAYS(a_ready_stall, !in_ready_o |-> out_stall, "input stalled while output free")

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid_o && $stable(out_data_o), "result changed")

endmodule

bind lru_limited_set lls_checker u_lls_checker (.*);

>>> bench/tb_lru_limited_set.sv
// ----------------------------------------------------------------------------
// tb_lru_limited_set
// self-checking bench for the recency-ordered key set: a short table of
// directed operations and capacity writes, then random phases over small key
// pools so hits, moves to front, removes and evictions all happen often; every
// result is compared against its expected table value where given, else an in-bench model of the recency list
// ----------------------------------------------------------------------------
module tb_lru_limited_set;
  import lls_pkg::*;

  localparam int unsigned Entries  = 16;
  localparam int unsigned PlanLen  = 21;
  localparam int unsigned PhaseCnt = 9;
  localparam int unsigned PhaseLen = 150;
  localparam logic [CapW-1:0] PhaseCaps [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd8,
                                                 5'd15, 5'd17};

  typedef struct {
    bit                   cfg;
    logic [CapW-1:0]      cap;
    cmd_e                 cmd;
    logic [KeyFieldW-1:0] key;
    bit                   typed;
    out_t                 want;
  } step_t;

  logic            clk_i;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  in_t             in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_t            out_data_o;
  logic            cfg_we_i    = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;

  // recency list model, slot 0 most recent
  logic [KeyFieldW-1:0] slot_key [Entries];
  int unsigned          held_cnt;
  logic [CapW-1:0]      cap_setting;

  out_t        pending_outcomes [$];
  out_t        oldest_want;
  int unsigned fault_count = 0;
  bit          result_taken = 1'b0;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  int unsigned sink_wait = 0;

  step_t plan [PlanLen];

  lru_limited_set dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("tb_lru_limited_set: done, errors");
    $finish;
  end

  function automatic void push_front(int unsigned upto, logic [KeyFieldW-1:0] key);
    for (int unsigned i = upto; i > 0; i--) slot_key[i] = slot_key[i-1];
    slot_key[0] = key;
  endfunction

  function automatic out_t lru_apply(cmd_e cmd, logic [KeyFieldW-1:0] key);
    out_t        res;
    int          pos;
    int unsigned lim;
    pos = -1;
    for (int unsigned i = 0; i < held_cnt; i++) begin
      if (pos < 0 && slot_key[i] == key) pos = i;
    end
    lim = (cap_setting == 0) ? 1 : ((cap_setting > Entries) ? Entries : cap_setting);
    res = '0;
    res.found = (pos >= 0);
    case (cmd)
      CMD_QUERY, CMD_ADD: begin
        if (pos >= 0) begin
          push_front(pos, key);
        end else if (cmd == CMD_ADD) begin
          if (held_cnt >= lim && held_cnt > 0) begin
            res.evicted     = 1'b1;
            res.evicted_key = slot_key[held_cnt-1];
            held_cnt--;
          end
          if (held_cnt < Entries) begin
            push_front(held_cnt, key);
            held_cnt++;
          end
        end
      end
      CMD_REMOVE: begin
        if (pos >= 0) begin
          for (int unsigned i = pos; i + 1 < held_cnt; i++) slot_key[i] = slot_key[i+1];
          held_cnt--;
        end
      end
      default: ;
    endcase
    res.occupancy = held_cnt[OccW-1:0];
    return res;
  endfunction

  // called at a rising edge, returns at the edge the transaction is taken
  task automatic send_op(cmd_e cmd, logic [KeyFieldW-1:0] key, bit typed, out_t want);
    in_t         item;
    out_t        predicted;
    int unsigned gap;
    bit          took;
    gap = src_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.cmd = cmd;
    item.key = key;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(negedge clk_i);
      took = (in_ready_o === 1'b1);
      @(posedge clk_i);
    end while (!took);
    predicted = lru_apply(cmd, key);
    pending_outcomes.insert(pending_outcomes.size(), typed ? want : predicted);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CapW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_setting = value;
  endtask

  // result side: a transaction completes at the edge after this sample
  always @(negedge clk_i) begin
    result_taken = (out_valid_o === 1'b1) && (out_ready_i === 1'b1);
    if (result_taken) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result transaction %h", out_data_o);
        fault_count++;
      end else begin
        oldest_want = pending_outcomes.pop_front();
        if (out_data_o.found !== oldest_want.found) begin
          $error("found: expected %0d, got %0d", oldest_want.found, out_data_o.found);
          fault_count++;
        end
        if (out_data_o.evicted !== oldest_want.evicted) begin
          $error("evicted: expected %0d, got %0d", oldest_want.evicted, out_data_o.evicted);
          fault_count++;
        end
        if (out_data_o.evicted_key !== oldest_want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", oldest_want.evicted_key,
                 out_data_o.evicted_key);
          fault_count++;
        end
        if (out_data_o.occupancy !== oldest_want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", oldest_want.occupancy,
                 out_data_o.occupancy);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (result_taken) sink_wait = sink_quiet ? 0 : $urandom_range(0, 6);
    else if (sink_wait > 0) sink_wait--;
    out_ready_i <= (sink_wait == 0);
  end

  initial begin : stimulus
    logic [KeyFieldW-1:0] pool [$];
    logic [KeyFieldW-1:0] key;
    int unsigned          pool_len;
    int unsigned          pick;
    cmd_e                 cmd;

    plan = '{
      '{1'b0, 5'd0,  CMD_QUERY,  32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'h0, 5'd0}},
      '{1'b0, 5'd0,  CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'h0, 5'd0}},
      '{1'b0, 5'd0,  CMD_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'h0, 5'd0}},
      '{1'b0, 5'd0,  CMD_ADD,    32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'h0, 5'd1}},
      '{1'b0, 5'd0,  CMD_ADD,    32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'h0, 5'd2}},
      '{1'b0, 5'd0,  CMD_QUERY,  32'h0000_0000, 1'b1, '{1'b1, 1'b0, 32'h0, 5'd2}},
      '{1'b0, 5'd0,  CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 32'h0, 5'd2}},
      '{1'b0, 5'd0,  CMD_QUERY,  32'h1234_5678, 1'b1, '{1'b0, 1'b0, 32'h0, 5'd2}},
      // capacity zero acts as one, below the current occupancy
      '{1'b1, 5'd0,  CMD_QUERY,  32'h0,         1'b0, '0},
      '{1'b0, 5'd0,  CMD_ADD,    32'h5555_5555, 1'b1, '{1'b0, 1'b1, 32'hFFFF_FFFF, 5'd2}},
      '{1'b0, 5'd0,  CMD_ADD,    32'hAAAA_AAAA, 1'b1, '{1'b0, 1'b1, 32'h0, 5'd2}},
      '{1'b0, 5'd0,  CMD_REMOVE, 32'h5555_5555, 1'b1, '{1'b1, 1'b0, 32'h0, 5'd1}},
      '{1'b0, 5'd0,  CMD_ADD,    32'h8000_0001, 1'b1, '{1'b0, 1'b1, 32'hAAAA_AAAA, 5'd1}},
      '{1'b1, 5'd2,  CMD_QUERY,  32'h0,         1'b0, '0},
      '{1'b0, 5'd0,  CMD_ADD,    32'h7FFF_FFFE, 1'b0, '0},
      '{1'b0, 5'd0,  CMD_ADD,    32'h0000_0001, 1'b0, '0},
      '{1'b0, 5'd0,  CMD_QUERY,  32'h7FFF_FFFE, 1'b0, '0},
      // above the slot count saturates
      '{1'b1, 5'd31, CMD_QUERY,  32'h0,         1'b0, '0},
      '{1'b0, 5'd0,  CMD_ADD,    32'hFFFF_FFFF, 1'b0, '0},
      '{1'b0, 5'd0,  CMD_ADD,    32'h0000_0000, 1'b0, '0},
      '{1'b0, 5'd0,  CMD_REMOVE, 32'h7FFF_FFFE, 1'b0, '0}
    };

    held_cnt    = 0;
    cap_setting = CapReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        settle();
        write_capacity(plan[i].cap);
      end else begin
        send_op(plan[i].cmd, plan[i].key, plan[i].typed, plan[i].want);
      end
    end

    for (int unsigned p = 0; p < PhaseCnt; p++) begin
      settle();
      write_capacity((p < 8) ? PhaseCaps[p] : CapW'($urandom_range(0, 31)));
      pool_len = $urandom_range(2, 24);
      pool.delete();
      repeat (pool_len) pool.insert(pool.size(), $urandom());
      for (int unsigned n = 0; n < PhaseLen; n++) begin
        if ($urandom_range(0, 39) == 0) src_quiet = ~src_quiet;
        if ($urandom_range(0, 39) == 0) sink_quiet <= ~sink_quiet;
        // hold off until the pipeline is empty
        if (n == PhaseLen / 2) settle();
        pick = $urandom_range(0, 99);
        if (pick < 45) cmd = CMD_ADD;
        else if (pick < 70) cmd = CMD_QUERY;
        else if (pick < 90) cmd = CMD_REMOVE;
        else cmd = CMD_LOOKUP;
        key = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, pool_len - 1)];
        send_op(cmd, key, 1'b0, '0);
      end
    end

    settle();
    if (fault_count == 0) $display("tb_lru_limited_set: done, clean");
    else $display("tb_lru_limited_set: done, errors");
    $finish;
  end

endmodule
